FILE: src/hseq_pkg.sv
// package: widths, constants and item types for the hall sensor edge qualifier
`default_nettype none
package hseq_pkg;

  // field widths
  localparam int unsigned CodeW     = 3;
  localparam int unsigned PortTimeW = 32;
  localparam int unsigned StabW     = 20;
  localparam int unsigned GlitchW   = 16;

  // default internal time width (timestamps wrap at this width)
  localparam int unsigned TimeBitsDef = 32;

  // constants
  localparam logic [StabW-1:0]   StabReset = StabW'(100);
  localparam logic [CodeW-1:0]   CodeLow   = CodeW'(1);
  localparam logic [CodeW-1:0]   CodeHigh  = CodeW'(6);
  localparam logic [GlitchW-1:0] GlitchMax = '1;

  // input item
  typedef struct packed {
    logic [CodeW-1:0]     raw_code;
    logic [PortTimeW-1:0] now_time;
  } in_item_t;

  // result item
  typedef struct packed {
    logic                 edge_valid;
    logic [CodeW-1:0]     edge_code;
    logic [PortTimeW-1:0] edge_time;
    logic [PortTimeW-1:0] edge_interval;
    logic [CodeW-1:0]     qualified_code;
    logic [GlitchW-1:0]   glitches;
    logic                 safe_to_clear;
  } out_item_t;

endpackage : hseq_pkg
`default_nettype wire

FILE: src/hseq_chan_if.sv
// interfaces: valid/ready channels for sample items and result items
`default_nettype none
interface hseq_in_if;
  logic                valid;
  logic                ready;
  hseq_pkg::in_item_t  item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface : hseq_in_if

interface hseq_out_if;
  logic                valid;
  logic                ready;
  hseq_pkg::out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface : hseq_out_if
`default_nettype wire

FILE: src/hall_sensor_edge_qualifier.sv
// top level: hall sensor edge qualifier with stability time
//
// Usage
//   in_i  (sink):   one item per hall sample, raw 3-bit code plus a wrapping
//                   microsecond timestamp. Items are taken on valid && ready.
//   out_o (source): exactly one result item per sample, in order, carrying the
//                   released edge (if any), the qualified code, the glitch
//                   count and the clear-safe flag.
//   cfg_we_i / cfg_data_i: writes the stability time in microseconds; write it
//                   only while no item is in flight.
// Path: an accepted sample sits in the input register, is evaluated and
//   lands in the result register when it advances, which waits while the
//   result register is full and out_o is not taken.
// Throughput: one item per cycle while out_o is taken, set by the single
//   evaluation step between input and result register, which updates state.
// Reset: the first sample after reset only initialises the qualified code and
//   edge reference time; stability time returns to 100 us.
// Stall: when out_o is not taken the result register holds, the input
//   register keeps one more item, and in_i.ready drops once both are full.
`default_nettype none
module hall_sensor_edge_qualifier #(
  parameter int unsigned TIME_BITS = hseq_pkg::TimeBitsDef
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          cfg_we_i,
  input  wire [hseq_pkg::StabW-1:0]    cfg_data_i,
  hseq_in_if.sink                      in_i,
  hseq_out_if.source                   out_o
);

  localparam int unsigned CmpW =
    (TIME_BITS > hseq_pkg::StabW) ? TIME_BITS : hseq_pkg::StabW;

  // stability time register
  logic [hseq_pkg::StabW-1:0] stab_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stab_q <= hseq_pkg::StabReset;
    end else if (cfg_we_i) begin
      stab_q <= cfg_data_i;
    end
  end

  // input register and result register handshake
  logic                s1_valid_q;
  hseq_pkg::in_item_t  s1_item_q;
  logic                res_valid_q;
  hseq_pkg::out_item_t res_item_q;
  logic                advance;

  assign advance     = s1_valid_q && (!res_valid_q || out_o.ready);
  assign in_i.ready  = !s1_valid_q || advance;
  assign out_o.valid = res_valid_q;
  assign out_o.item  = res_item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q <= in_i.item;
    end
  end

  // qualifier state
  logic                         started_q, started_d;
  logic [hseq_pkg::CodeW-1:0]   last_raw_q, last_raw_d;
  logic [hseq_pkg::CodeW-1:0]   accepted_q, accepted_d;
  logic [hseq_pkg::CodeW-1:0]   pend_code_q, pend_code_d;
  logic                         pending_q, pending_d;
  logic [TIME_BITS-1:0]         pend_since_q, pend_since_d;
  logic [TIME_BITS-1:0]         last_edge_q, last_edge_d;
  logic [hseq_pkg::GlitchW-1:0] glitch_q, glitch_d;

  logic [hseq_pkg::CodeW-1:0] code;
  logic [TIME_BITS-1:0]       now;
  logic [TIME_BITS-1:0]       held_time;
  logic                       held;
  logic                       release_edge;
  hseq_pkg::out_item_t        res_d;

  assign code      = s1_item_q.raw_code;
  assign now       = TIME_BITS'(s1_item_q.now_time);
  assign held_time = now - pend_since_q;
  assign held      = pending_q && (CmpW'(held_time) >= CmpW'(stab_q));

  // one evaluation step for the item in the input register
  always_comb begin
    started_d    = started_q;
    last_raw_d   = last_raw_q;
    accepted_d   = accepted_q;
    pend_code_d  = pend_code_q;
    pending_d    = pending_q;
    pend_since_d = pend_since_q;
    last_edge_d  = last_edge_q;
    glitch_d     = glitch_q;
    release_edge = 1'b0;

    if (!started_q) begin
      // first sample only initialises
      started_d    = 1'b1;
      last_raw_d   = code;
      accepted_d   = code;
      pend_code_d  = '0;
      pending_d    = 1'b0;
      pend_since_d = '0;
      last_edge_d  = now;
      glitch_d     = '0;
    end else begin
      if (held) begin
        // candidate has held long enough: release it
        release_edge = 1'b1;
        accepted_d   = pend_code_q;
        last_edge_d  = pend_since_q;
        pending_d    = 1'b0;
      end else if (pending_q && (code != last_raw_q)) begin
        // early change drops the candidate as a glitch
        if (glitch_q != hseq_pkg::GlitchMax) begin
          glitch_d = glitch_q + 1'b1;
        end
        pending_d = 1'b0;
      end
      if (code != last_raw_q) begin
        // follow the raw change, maybe starting a new candidate
        last_raw_d = code;
        if (code != accepted_d) begin
          pend_code_d  = code;
          pend_since_d = now;
          pending_d    = 1'b1;
        end
      end
    end

    res_d.edge_valid     = release_edge;
    res_d.edge_code      = release_edge ? pend_code_q : '0;
    res_d.edge_time      = release_edge ? hseq_pkg::PortTimeW'(pend_since_q) : '0;
    res_d.edge_interval  = release_edge ?
                           hseq_pkg::PortTimeW'(pend_since_q - last_edge_q) : '0;
    res_d.qualified_code = accepted_d;
    res_d.glitches       = glitch_d;
    res_d.safe_to_clear  = !pending_d && (code >= hseq_pkg::CodeLow) &&
                           (code <= hseq_pkg::CodeHigh) && (code == last_raw_d) &&
                           (code == accepted_d);
  end

  // state update when the item moves on
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      last_raw_q   <= '0;
      accepted_q   <= '0;
      pend_code_q  <= '0;
      pending_q    <= 1'b0;
      pend_since_q <= '0;
      last_edge_q  <= '0;
      glitch_q     <= '0;
    end else if (advance) begin
      started_q    <= started_d;
      last_raw_q   <= last_raw_d;
      accepted_q   <= accepted_d;
      pend_code_q  <= pend_code_d;
      pending_q    <= pending_d;
      pend_since_q <= pend_since_d;
      last_edge_q  <= last_edge_d;
      glitch_q     <= glitch_d;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (advance) begin
      res_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_item_q <= res_d;
    end
  end

endmodule : hall_sensor_edge_qualifier
`default_nettype wire

FILE: sim/tb.sv
// testbench for the hall sensor edge qualifier: shadow model, stimulus and result checks
`timescale 1ns / 100ps

import hseq_pkg::*;

// shadow copy of the qualifier state, predicts one report per sample item
class edge_qualifier_shadow;
  logic [StabW-1:0]     stability;
  bit                   started;
  logic [CodeW-1:0]     last_raw;
  logic [CodeW-1:0]     accepted;
  logic [CodeW-1:0]     cand_code;
  bit                   cand_live;
  logic [PortTimeW-1:0] cand_since;
  logic [PortTimeW-1:0] last_edge;
  logic [GlitchW-1:0]   glitch_tally;
  out_item_t            due_reports[$];
  int unsigned          failures;

  function new();
    stability    = StabReset;
    started      = 0;
    last_raw     = '0;
    accepted     = '0;
    cand_code    = '0;
    cand_live    = 0;
    cand_since   = '0;
    last_edge    = '0;
    glitch_tally = '0;
    failures     = 0;
  endfunction

  function void set_stability(logic [StabW-1:0] value);
    stability = value;
  endfunction

  // candidate age against the stability time, wrapping
  function bit held_long(logic [PortTimeW-1:0] now);
    logic [PortTimeW-1:0] age;
    age = now - cand_since;
    return age >= PortTimeW'(stability);
  endfunction

  // release the candidate as a qualified edge
  function void release_edge(inout out_item_t rep);
    rep.edge_valid    = 1'b1;
    rep.edge_code     = cand_code;
    rep.edge_time     = cand_since;
    rep.edge_interval = cand_since - last_edge;
    accepted          = cand_code;
    last_edge         = cand_since;
    cand_live         = 0;
  endfunction

  function void note_sample(in_item_t smp);
    out_item_t            rep;
    logic [CodeW-1:0]     code;
    logic [PortTimeW-1:0] now;
    rep  = '0;
    code = smp.raw_code;
    now  = smp.now_time;
    if (!started) begin
      // first sample only starts the block
      started    = 1;
      last_raw   = code;
      accepted   = code;
      cand_code  = '0;
      cand_live  = 0;
      cand_since = '0;
      last_edge  = now;
    end else if (code != last_raw) begin
      if (cand_live && held_long(now)) begin
        release_edge(rep);
      end else if (cand_live) begin
        if (glitch_tally != GlitchMax) glitch_tally++;
        cand_live = 0;
      end
      last_raw = code;
      if (code != accepted) begin
        cand_code  = code;
        cand_since = now;
        cand_live  = 1;
      end
    end else if (cand_live && held_long(now)) begin
      release_edge(rep);
    end
    rep.qualified_code = started ? accepted : '0;
    rep.glitches       = glitch_tally;
    rep.safe_to_clear  = started && !cand_live && code >= CodeLow && code <= CodeHigh &&
                         code == last_raw && code == accepted;
    due_reports.push_back(rep);
  endfunction

  function void check_field(string name, logic [PortTimeW-1:0] want, logic [PortTimeW-1:0] got);
    if (got !== want) begin
      failures++;
      $display("%0t mismatch %s: expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  function void check_report(out_item_t got);
    out_item_t want;
    if (due_reports.size() == 0) begin
      failures++;
      $display("%0t unexpected result: expected none, actual %h", $time, got);
      return;
    end
    want = due_reports.pop_front();
    check_field("edge_valid", want.edge_valid, got.edge_valid);
    check_field("edge_code", want.edge_code, got.edge_code);
    check_field("edge_time", want.edge_time, got.edge_time);
    check_field("edge_interval", want.edge_interval, got.edge_interval);
    check_field("qualified_code", want.qualified_code, got.qualified_code);
    check_field("glitches", want.glitches, got.glitches);
    check_field("safe_to_clear", want.safe_to_clear, got.safe_to_clear);
  endfunction
endclass

module tb;

  localparam int unsigned QuietLimit = 3000;
  localparam int unsigned HoldCycles = 400;
  localparam int unsigned PhaseItems = 280;

  logic             clk;
  logic             rst_n;
  logic             cfg_we;
  logic [StabW-1:0] cfg_data;

  hseq_in_if  in_ch ();
  hseq_out_if out_ch ();

  hall_sensor_edge_qualifier dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_data_i (cfg_data),
    .in_i       (in_ch),
    .out_o      (out_ch)
  );

  edge_qualifier_shadow shadow;

  logic [StabW-1:0]     stab_now;
  logic [PortTimeW-1:0] t_us;
  bit                   idle_en;
  bit                   hold_off_req;
  int unsigned          sent_count;
  int unsigned          quiet;

  // clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // position in the hall commutation order
  function automatic logic [CodeW-1:0] hall_step(int idx);
    case (idx)
      0: return 3'd1;
      1: return 3'd3;
      2: return 3'd2;
      3: return 3'd6;
      4: return 3'd4;
      default: return 3'd5;
    endcase
  endfunction

  // gap shorter than the stability time (zero when the stability time is zero)
  function automatic logic [PortTimeW-1:0] short_gap();
    if (stab_now == 0) return '0;
    return $urandom_range(int'(stab_now) - 1);
  endfunction

  // gap around the stability boundary, short, long or wrapping
  function automatic logic [PortTimeW-1:0] pick_gap();
    int unsigned s;
    s = stab_now;
    case ($urandom_range(9))
      0: return '0;
      1, 2, 3: return s + $urandom_range(s / 2 + 2);
      4: return s;
      5: return (s == 0) ? 0 : s - 1;
      6: return short_gap();
      7: return $urandom;
      default: return $urandom_range(2 * s + 4, 1);
    endcase
  endfunction

  // offer one sample item and wait for it to be taken
  task automatic send_sample(logic [CodeW-1:0] code, logic [PortTimeW-1:0] stamp);
    in_item_t smp;
    smp.raw_code = code;
    smp.now_time = stamp;
    @(negedge clk);
    while (idle_en && $urandom_range(99) < 25) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.item  <= smp;
    do @(posedge clk); while (!in_ch.ready);
    shadow.note_sample(smp);
    sent_count++;
  endtask

  task automatic send_after(logic [CodeW-1:0] code, logic [PortTimeW-1:0] gap);
    t_us = t_us + gap;
    send_sample(code, t_us);
  endtask

  // drop valid and let every outstanding report arrive
  task automatic drain();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (shadow.due_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_stability(logic [StabW-1:0] value);
    drain();
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(negedge clk);
    cfg_we   <= 1'b0;
    stab_now = value;
    shadow.set_stability(value);
  endtask

  // well-formed rotation with random dwell, some contact bounce
  task automatic run_commutation(int steps);
    int               dir;
    int               idx;
    logic [CodeW-1:0] code;
    logic [CodeW-1:0] prev;
    dir  = $urandom_range(1) ? 1 : 5;
    idx  = $urandom_range(5);
    prev = hall_step(idx);
    for (int s = 0; s < steps; s++) begin
      idx  = (idx + dir) % 6;
      code = hall_step(idx);
      if ($urandom_range(4) == 0) begin
        send_after(code, short_gap());
        send_after(prev, short_gap());
      end
      repeat ($urandom_range(4, 1)) send_after(code, pick_gap());
      prev = code;
    end
  endtask

  // any code, including 0 and 7, with odd timing or a jump in time
  task automatic run_noise(int count);
    repeat (count) begin
      if ($urandom_range(5) == 0) t_us = $urandom;
      send_after($urandom_range(7), pick_gap());
    end
  endtask

  // receiver: random stalls, one long hold-off on request
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        out_ch.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk);
        hold_off_req = 0;
      end else begin
        out_ch.ready <= !idle_en || ($urandom_range(99) >= 25);
      end
    end
  end

  // result checks and watchdog on handshake activity
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) shadow.check_report(out_ch.item);
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= QuietLimit) begin
      $display("hall_sensor_edge_qualifier regression: fail");
      $finish;
    end
  end

  // stimulus
  initial begin
    logic [StabW-1:0]  value;
    int unsigned       phase_start;
    bit                hold_done;
    shadow       = new();
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_data     = '0;
    in_ch.valid  = 1'b0;
    in_ch.item   = '0;
    idle_en      = 1;
    hold_off_req = 0;
    hold_done    = 0;
    sent_count   = 0;
    quiet        = 0;
    stab_now     = StabReset;
    t_us         = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // directed: start, exact boundary, early drop, release on change, odd codes, wrap
    send_sample(3'd5, 32'hFFFF_FFC0);
    send_sample(3'd5, 32'hFFFF_FFD0);
    send_sample(3'd4, 32'hFFFF_FFE0);
    send_sample(3'd4, 32'h0000_0010);
    send_sample(3'd4, 32'h0000_0044);
    send_sample(3'd4, 32'h0000_0050);
    send_sample(3'd6, 32'h0000_0060);
    send_sample(3'd4, 32'h0000_0070);
    send_sample(3'd6, 32'h0000_0080);
    send_sample(3'd6, 32'h0000_00E3);
    send_sample(3'd2, 32'h0000_0200);
    send_sample(3'd0, 32'h0000_0210);
    send_sample(3'd0, 32'h0000_0300);
    send_sample(3'd0, 32'h0000_0310);
    send_sample(3'd7, 32'h0000_0320);
    send_sample(3'd7, 32'h7FFF_FFFF);
    send_sample(3'd7, 32'h8000_0000);
    send_sample(3'd1, 32'h8000_0001);
    send_sample(3'd3, 32'h8000_0002);
    send_sample(3'd3, 32'hFFFF_FFFF);
    send_sample(3'd3, 32'h0000_0000);
    send_sample(3'd6, 32'h0000_0000);
    send_sample(3'd6, 32'h0000_0063);
    send_sample(3'd6, 32'h0000_0064);
    t_us = 32'h0000_0064;

    // random phases, one stability setting each
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: value = '0;
        1: value = '1;
        2: value = $urandom_range(40, 1);
        3: value = $urandom_range(1000, 1);
        4: value = $urandom_range(20'hFFFFF);
        default: value = StabReset;
      endcase
      write_stability(value);
      idle_en     = (phase != 2);
      phase_start = sent_count;
      while (sent_count - phase_start < PhaseItems) begin
        if (phase == 3 && !hold_done && sent_count - phase_start > 100) begin
          hold_off_req = 1;
          hold_done    = 1;
        end
        if ($urandom_range(9) < 7) run_commutation($urandom_range(12, 3));
        else run_noise($urandom_range(6, 1));
      end
    end

    drain();
    if (shadow.failures == 0 && shadow.due_reports.size() == 0) begin
      $display("hall_sensor_edge_qualifier regression: pass");
    end else begin
      $display("hall_sensor_edge_qualifier regression: fail");
    end
    $finish;
  end

endmodule

FILE: files.f
src/hseq_pkg.sv
src/hseq_chan_if.sv
src/hall_sensor_edge_qualifier.sv
sim/tb.sv
